/* rtl/bgdp_pkg.sv */
// Package for the bar graph delta painter: field widths, register indexes,
// configuration and command structs, palette table and top-row helper.
// No dependencies.
`default_nettype none

package bgdp_pkg;

  // Field widths
  localparam int unsigned IdxW    = 5;
  localparam int unsigned HeightW = 16;
  localparam int unsigned RowW    = 10;
  localparam int unsigned ColW    = 10;
  localparam int unsigned SpanW   = 6;
  localparam int unsigned ColorW  = 16;
  localparam int unsigned PixW    = 21;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_SCREEN_HEIGHT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_BAR_X   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BAR_PITCH     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BAR_SPAN      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ERASE_COLOR   = 3'd4;

  // Register reset values
  localparam logic [RowW-1:0]   SCREEN_HEIGHT_RST = 10'd480;
  localparam logic [ColW-1:0]   FIRST_BAR_X_RST   = 10'd5;
  localparam logic [ColW-1:0]   BAR_PITCH_RST     = 10'd15;
  localparam logic [SpanW-1:0]  BAR_SPAN_RST      = 6'd4;
  localparam logic [ColorW-1:0] ERASE_COLOR_RST   = 16'h0000;

  // Defaults for top-level parameters and internal sizes
  localparam int unsigned BAR_COUNT_DEF = 32;
  localparam int unsigned CmdQueueDepth = 2;

  typedef struct packed {
    logic [RowW-1:0]   screen_height;
    logic [ColW-1:0]   first_bar_x;
    logic [ColW-1:0]   bar_pitch;
    logic [SpanW-1:0]  bar_span;
    logic [ColorW-1:0] erase_color;
  } bgdp_cfg_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic [IdxW-1:0] bar_index;
    logic [RowW-1:0] old_top;
    logic [RowW-1:0] new_top;
    logic            erase;
  } bgdp_cmd_t;

  // Bar colors, one per group of four bars
  function automatic logic [ColorW-1:0] bgdp_palette(input logic [2:0] slot);
    logic [ColorW-1:0] color;
    case (slot)
      3'd0:    color = 16'h00FF;
      3'd1:    color = 16'hFF00;
      3'd2:    color = 16'hF0F0;
      3'd3:    color = 16'h0F0F;
      3'd4:    color = 16'hAAAA;
      3'd5:    color = 16'hA0A0;
      3'd6:    color = 16'h0A0A;
      default: color = 16'hAA00;
    endcase
    return color;
  endfunction

  // Top row of a bar; an empty bar sits on the last row
  function automatic logic [RowW-1:0] bgdp_top_row(input logic [RowW-1:0] height,
                                                   input logic [RowW-1:0] screen_height);
    logic [RowW-1:0] top;
    if (height == '0) begin
      top = screen_height - RowW'(1);
    end else begin
      top = screen_height - height;
    end
    return top;
  endfunction

endpackage

`default_nettype wire

/* rtl/bgdp_if.sv */
// Valid/ready channel interfaces for the bar graph delta painter.
// Depends on bgdp_pkg for field widths.
`default_nettype none

interface bgdp_in_if
  import bgdp_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [IdxW-1:0]           bar_index;
  logic signed [HeightW-1:0] new_height;

  modport source (output valid, output bar_index, output new_height, input ready);
  modport sink   (input valid, input bar_index, input new_height, output ready);
endinterface

interface bgdp_out_if
  import bgdp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ColW-1:0]   x_first;
  logic [ColW-1:0]   x_last;
  logic [RowW-1:0]   y_first;
  logic [RowW-1:0]   y_last;
  logic [ColorW-1:0] paint_color;
  logic [PixW-1:0]   pixel_count;
  logic              is_erase;

  modport source (output valid, output x_first, output x_last, output y_first,
                  output y_last, output paint_color, output pixel_count,
                  output is_erase, input ready);
  modport sink   (input valid, input x_first, input x_last, input y_first,
                  input y_last, input paint_color, input pixel_count,
                  input is_erase, output ready);
endinterface

`default_nettype wire

/* rtl/bar_graph_delta_painter_core.sv */
// Bar graph delta painter: one bar height in, at most one rectangle out.
// Path: a changed bar's command is registered in the queue after the front compare,
// and its rectangle then in the output register. Throughput: one transaction per
// cycle while the queue has room, set by the single height store read-modify-write.
// Reset: asynchronous active low; control registers to defaults, heights to 0.
`default_nettype none

module bar_graph_delta_painter_core
  import bgdp_pkg::*;
#(
  parameter int unsigned BAR_COUNT = BAR_COUNT_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  bgdp_in_if.sink                  in_i,
  bgdp_out_if.source               out_o
);

  bgdp_cfg_t cfg_q;
  logic      push;
  bgdp_cmd_t push_cmd;
  logic      queue_full;
  logic      pop;
  logic      head_valid;
  bgdp_cmd_t head_cmd;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_height <= SCREEN_HEIGHT_RST;
      cfg_q.first_bar_x   <= FIRST_BAR_X_RST;
      cfg_q.bar_pitch     <= BAR_PITCH_RST;
      cfg_q.bar_span      <= BAR_SPAN_RST;
      cfg_q.erase_color   <= ERASE_COLOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_wdata_i[RowW-1:0];
        CFG_FIRST_BAR_X:   cfg_q.first_bar_x   <= cfg_wdata_i[ColW-1:0];
        CFG_BAR_PITCH:     cfg_q.bar_pitch     <= cfg_wdata_i[ColW-1:0];
        CFG_BAR_SPAN:      cfg_q.bar_span      <= cfg_wdata_i[SpanW-1:0];
        CFG_ERASE_COLOR:   cfg_q.erase_color   <= cfg_wdata_i[ColorW-1:0];
        default: ;
      endcase
    end
  end

  bgdp_front #(
    .BAR_COUNT(BAR_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .bar_index_i (in_i.bar_index),
    .new_height_i(in_i.new_height),
    .queue_full_i(queue_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  bgdp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .full_o    (queue_full),
    .pop_i     (pop),
    .valid_o   (head_valid),
    .head_o    (head_cmd)
  );

  bgdp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_valid_i  (head_valid),
    .cmd_i        (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .x_first_o    (out_o.x_first),
    .x_last_o     (out_o.x_last),
    .y_first_o    (out_o.y_first),
    .y_last_o     (out_o.y_last),
    .paint_color_o(out_o.paint_color),
    .pixel_count_o(out_o.pixel_count),
    .is_erase_o   (out_o.is_erase)
  );

endmodule

`default_nettype wire

/* rtl/bgdp_front.sv */
// Front end: holds previous bar heights, clamps and compares each new height,
// and pushes a command for every bar that changed. Depends on bgdp_pkg.
`default_nettype none

module bgdp_front
  import bgdp_pkg::*;
#(
  parameter int unsigned BAR_COUNT = BAR_COUNT_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire bgdp_cfg_t                 cfg_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [IdxW-1:0]           bar_index_i,
  input  wire logic signed [HeightW-1:0] new_height_i,
  input  wire logic                      queue_full_i,
  output logic                           push_o,
  output bgdp_cmd_t                      cmd_o
);

  localparam int unsigned MaxBars   = 1 << IdxW;
  localparam int unsigned StoreDepth = (BAR_COUNT < MaxBars) ? BAR_COUNT : MaxBars;
  localparam int unsigned StoreIdxW  = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam logic [IdxW+1:0] BarLimit = (IdxW + 2)'(BAR_COUNT);

  logic [RowW-1:0] heights_q [StoreDepth];

  logic                 accept;
  logic                 in_range;
  logic [StoreIdxW-1:0] slot;
  logic [RowW-1:0]      stored_h;
  logic [RowW-1:0]      old_h;
  logic [RowW-1:0]      new_h;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = {2'b00, bar_index_i} < BarLimit;
  assign slot       = bar_index_i[StoreIdxW-1:0];
  assign stored_h   = heights_q[slot];

  // Clamp both heights to the current screen
  always_comb begin
    if (new_height_i[HeightW-1]) begin
      new_h = '0;
    end else if (new_height_i[HeightW-2:0] > (HeightW-1)'(cfg_i.screen_height)) begin
      new_h = cfg_i.screen_height;
    end else begin
      new_h = new_height_i[RowW-1:0];
    end
    old_h = (stored_h > cfg_i.screen_height) ? cfg_i.screen_height : stored_h;
  end

  // Emit a command only for a changed bar
  assign push_o            = accept && in_range && (new_h != old_h);
  assign cmd_o.bar_index   = bar_index_i;
  assign cmd_o.old_top     = bgdp_top_row(old_h, cfg_i.screen_height);
  assign cmd_o.new_top     = bgdp_top_row(new_h, cfg_i.screen_height);
  assign cmd_o.erase       = new_h < old_h;

  // Store the clamped height
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < StoreDepth; i++) begin
        heights_q[i] <= '0;
      end
    end else if (accept && in_range) begin
      heights_q[slot] <= new_h;
    end
  end

endmodule

`default_nettype wire

/* rtl/bgdp_queue.sv */
// Short command queue between front and back ends.
// Depends on bgdp_pkg for the command struct.
`default_nettype none

module bgdp_queue
  import bgdp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire bgdp_cmd_t push_cmd_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           valid_o,
  output bgdp_cmd_t      head_o
);

  localparam int unsigned PtrW = (CmdQueueDepth > 1) ? $clog2(CmdQueueDepth) : 1;
  localparam int unsigned CntW = $clog2(CmdQueueDepth + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(CmdQueueDepth);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(CmdQueueDepth - 1);

  bgdp_cmd_t       entries_q [CmdQueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = count_q == CntMax;
  assign valid_o = count_q != '0;
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold command payloads
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/bgdp_back.sv */
// Back end: turns a queued command into a rectangle transaction and holds it
// in the output register until taken. Depends on bgdp_pkg.
`default_nettype none

module bgdp_back
  import bgdp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire bgdp_cfg_t   cfg_i,
  input  wire logic        cmd_valid_i,
  input  wire bgdp_cmd_t   cmd_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [ColW-1:0]  x_first_o,
  output logic [ColW-1:0]  x_last_o,
  output logic [RowW-1:0]  y_first_o,
  output logic [RowW-1:0]  y_last_o,
  output logic [ColorW-1:0] paint_color_o,
  output logic [PixW-1:0]  pixel_count_o,
  output logic             is_erase_o
);

  logic                      valid_q;
  logic [ColW-1:0]           x_first_q, x_first_d;
  logic [ColW-1:0]           x_last_q, x_last_d;
  logic [RowW-1:0]           y_first_q, y_first_d;
  logic [RowW-1:0]           y_last_q, y_last_d;
  logic [ColorW-1:0]         color_q, color_d;
  logic [PixW-1:0]           pix_q, pix_d;
  logic                      erase_q;
  logic [ColW+IdxW-1:0]      offset;
  logic [RowW:0]             rows;
  logic [SpanW:0]            cols;
  logic [SpanW+RowW+1:0]     area;

  // Load when the output register is free or being drained
  assign pop_o = cmd_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    offset    = (ColW + IdxW)'(cfg_i.bar_pitch) * (ColW + IdxW)'(cmd_i.bar_index);
    x_first_d = cfg_i.first_bar_x + offset[ColW-1:0];
    x_last_d  = x_first_d + ColW'(cfg_i.bar_span);
    if (cmd_i.erase) begin
      y_first_d = cmd_i.old_top;
      y_last_d  = cmd_i.new_top;
      color_d   = cfg_i.erase_color;
    end else begin
      y_first_d = cmd_i.new_top;
      y_last_d  = cmd_i.old_top;
      color_d   = bgdp_palette(cmd_i.bar_index[IdxW-1:2]);
    end
    rows  = {1'b0, RowW'(y_last_d - y_first_d)} + (RowW + 1)'(1);
    cols  = {1'b0, cfg_i.bar_span} + (SpanW + 1)'(1);
    area  = (SpanW + RowW + 2)'(cols) * (SpanW + RowW + 2)'(rows);
    pix_d = PixW'(area);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Hold the rectangle payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      x_first_q <= x_first_d;
      x_last_q  <= x_last_d;
      y_first_q <= y_first_d;
      y_last_q  <= y_last_d;
      color_q   <= color_d;
      pix_q     <= pix_d;
      erase_q   <= cmd_i.erase;
    end
  end

  assign out_valid_o   = valid_q;
  assign x_first_o     = x_first_q;
  assign x_last_o      = x_last_q;
  assign y_first_o     = y_first_q;
  assign y_last_o      = y_last_q;
  assign paint_color_o = color_q;
  assign pixel_count_o = pix_q;
  assign is_erase_o    = erase_q;

endmodule

`default_nettype wire

/* rtl/bgdp_checker.sv */
// Port-level checks for the bar graph delta painter, bound to the top level.
// Depends on bgdp_pkg for field widths.
`default_nettype none

module bgdp_checker
  import bgdp_pkg::*;
(
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire logic [RowW-1:0] y_first,
  input wire logic [RowW-1:0] y_last,
  input wire logic [PixW-1:0] pixel_count
);

  // Hold a stalled transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("output transaction dropped while stalled");

  // Rectangle rows run top to bottom
  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> y_first <= y_last)
    else $error("rectangle rows out of order");

  // Every rectangle covers pixels and never more than the widest bar area
  a_pix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (pixel_count != '0) && (pixel_count <= PixW'(64 * 1024)))
    else $error("pixel count out of range");

endmodule

bind bar_graph_delta_painter_core bgdp_checker u_bgdp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .y_first    (out_o.y_first),
  .y_last     (out_o.y_last),
  .pixel_count(out_o.pixel_count)
);

`default_nettype wire

/* tb/tb.sv */
// Self-checking bench for bar_graph_delta_painter_core: bar heights go in over
// bgdp_in_if, rectangles are checked on bgdp_out_if against a bar-height tracker.
// Depends on bgdp_pkg, bgdp_if and the core RTL.
`default_nettype none

module tb;
  import bgdp_pkg::*;

  localparam int unsigned HalfPeriod   = 6;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned RandPhases   = 9;
  localparam int unsigned PhaseItems   = 200;
  localparam int unsigned ReportMax    = 10;
  localparam longint unsigned RunLimit = 64'd12_000_000;

  typedef struct packed {
    logic [ColW-1:0]   x_first;
    logic [ColW-1:0]   x_last;
    logic [RowW-1:0]   y_first;
    logic [RowW-1:0]   y_last;
    logic [ColorW-1:0] paint_color;
    logic [PixW-1:0]   pixel_count;
    logic              is_erase;
  } rect_t;

  typedef struct {
    logic [IdxW-1:0]    bar;
    logic [HeightW-1:0] height;
  } height_item_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  bgdp_in_if  in_if ();
  bgdp_out_if out_if ();

  bar_graph_delta_painter_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if.sink),
    .out_o       (out_if.source)
  );

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  // Tracker of the painter: registers, stored bar heights and bar colors
  bgdp_cfg_t         cfg_m;
  logic [RowW-1:0]   bar_heights [BAR_COUNT_DEF];
  logic [ColorW-1:0] bar_palette [8] = '{16'h00FF, 16'hFF00, 16'hF0F0, 16'h0F0F,
                                         16'hAAAA, 16'hA0A0, 16'h0A0A, 16'hAA00};

  height_item_t height_q[$];
  rect_t        pending_rects[$];

  int unsigned tx_gap;
  int unsigned rx_gap;
  bit          tx_burst;
  bit          rx_burst;
  int unsigned hold_left    = 0;
  int unsigned hold_req_cnt = 0;
  int unsigned hold_ack_cnt = 0;

  int unsigned heights_sent;
  int unsigned rects_seen;
  int unsigned settings_seen;
  int unsigned mismatches;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [RowW-1:0] bar_top_row(input logic [RowW-1:0] h);
    if (h == '0) return cfg_m.screen_height - RowW'(1);
    return cfg_m.screen_height - h;
  endfunction

  // Clamp, compare with the stored height, store, and queue the rectangle if any
  task automatic predict_rect(input logic [IdxW-1:0] idx, input logic [HeightW-1:0] raw);
    logic [RowW-1:0] h_new;
    logic [RowW-1:0] h_old;
    logic [RowW-1:0] dy;
    int unsigned     x0;
    int unsigned     pix;
    rect_t           r;
    if (raw[HeightW-1]) begin
      h_new = '0;
    end else if (raw > HeightW'(cfg_m.screen_height)) begin
      h_new = cfg_m.screen_height;
    end else begin
      h_new = raw[RowW-1:0];
    end
    h_old = bar_heights[idx];
    if (h_old > cfg_m.screen_height) h_old = cfg_m.screen_height;
    bar_heights[idx] = h_new;
    if (h_new == h_old) return;

    r.is_erase = h_new < h_old;
    if (r.is_erase) begin
      r.y_first     = bar_top_row(h_old);
      r.y_last      = bar_top_row(h_new);
      r.paint_color = cfg_m.erase_color;
    end else begin
      r.y_first     = bar_top_row(h_new);
      r.y_last      = bar_top_row(h_old);
      r.paint_color = bar_palette[idx[4:2]];
    end
    x0            = 32'(cfg_m.first_bar_x) + 32'(cfg_m.bar_pitch) * 32'(idx);
    r.x_first     = x0[ColW-1:0];
    r.x_last      = r.x_first + ColW'(cfg_m.bar_span);
    dy            = r.y_last - r.y_first;
    pix           = (32'(cfg_m.bar_span) + 32'd1) * (32'(dy) + 32'd1);
    r.pixel_count = pix[PixW-1:0];
    pending_rects.push_back(r);
  endtask

  task automatic check_rect();
    rect_t want;
    rect_t got;
    got = '{out_if.x_first, out_if.x_last, out_if.y_first, out_if.y_last,
            out_if.paint_color, out_if.pixel_count, out_if.is_erase};
    rects_seen++;
    if (pending_rects.size() == 0) begin
      mismatches++;
      if (mismatches <= ReportMax)
        $display("%0t unexpected rect x %0d..%0d y %0d..%0d c %h n %0d e %0b", $realtime,
                 got.x_first, got.x_last, got.y_first, got.y_last, got.paint_color,
                 got.pixel_count, got.is_erase);
      return;
    end
    want = pending_rects.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= ReportMax) begin
        $display("%0t rect mismatch: expected x %0d..%0d y %0d..%0d c %h n %0d e %0b",
                 $realtime, want.x_first, want.x_last, want.y_first, want.y_last,
                 want.paint_color, want.pixel_count, want.is_erase);
        $display("                 actual   x %0d..%0d y %0d..%0d c %h n %0d e %0b",
                 got.x_first, got.x_last, got.y_first, got.y_last, got.paint_color,
                 got.pixel_count, got.is_erase);
      end
    end
  endtask

  // Driver: predict on each accepted transaction, then offer the next height
  always @(posedge clk_i) begin
    height_item_t nxt;
    logic         fire;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      tx_gap      <= 0;
    end else begin
      fire = in_if.valid && in_if.ready;
      if (fire) begin
        predict_rect(in_if.bar_index, in_if.new_height);
        heights_sent++;
      end
      if (!in_if.valid || fire) begin
        if (tx_gap != 0) begin
          tx_gap      <= tx_gap - 1;
          in_if.valid <= 1'b0;
        end else if (height_q.size() != 0) begin
          nxt              = height_q.pop_front();
          in_if.valid      <= 1'b1;
          in_if.bar_index  <= nxt.bar;
          in_if.new_height <= nxt.height;
          tx_gap           <= tx_burst ? 0 : pick_gap();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted rectangle and stall ready at random
  always @(posedge clk_i) begin
    logic        fire;
    int unsigned gap;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_gap       <= 0;
    end else begin
      fire = out_if.valid && out_if.ready;
      if (fire) check_rect();
      gap = rx_gap;
      if (gap != 0) begin
        gap = gap - 1;
      end else if (!rx_burst && (fire || $urandom_range(0, 19) == 0)) begin
        gap = pick_gap();
      end
      rx_gap       <= gap;
      out_if.ready <= (gap == 0) && (hold_left == 0);
    end
  end

  // Long receiver hold-off, counted here on request
  always @(posedge clk_i) begin
    if (hold_req_cnt != hold_ack_cnt) begin
      hold_ack_cnt <= hold_req_cnt;
      hold_left    <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic queue_height(input logic [IdxW-1:0] bar, input logic [HeightW-1:0] h);
    height_item_t it;
    it.bar    = bar;
    it.height = h;
    height_q.push_back(it);
  endtask

  // Wait until every height is in and every rectangle out, then let the pipe empty
  task automatic drain();
    do @(negedge clk_i);
    while (height_q.size() != 0 || in_if.valid || pending_rects.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_SCREEN_HEIGHT: cfg_m.screen_height = data[RowW-1:0];
      CFG_FIRST_BAR_X:   cfg_m.first_bar_x   = data[ColW-1:0];
      CFG_BAR_PITCH:     cfg_m.bar_pitch     = data[ColW-1:0];
      CFG_BAR_SPAN:      cfg_m.bar_span      = data[SpanW-1:0];
      CFG_ERASE_COLOR:   cfg_m.erase_color   = data[ColorW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Pick a register setting, extremes often, junk above the field sometimes
  task automatic random_config();
    int unsigned         r;
    logic [CfgDataW-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 15) v = 1023;
    else if (r < 25) v = 1;
    else if (r < 35) v = CfgDataW'($urandom_range(2, 8));
    else v = CfgDataW'($urandom_range(16, 640));
    if ($urandom_range(0, 3) == 0) v = v | (CfgDataW'($urandom) << RowW);
    write_reg(CFG_SCREEN_HEIGHT, v);

    r = $urandom_range(0, 99);
    if (r < 15) v = 1023;
    else if (r < 25) v = 0;
    else v = CfgDataW'($urandom_range(0, 1023));
    if ($urandom_range(0, 3) == 0) v = v | (CfgDataW'($urandom) << ColW);
    write_reg(CFG_FIRST_BAR_X, v);

    r = $urandom_range(0, 99);
    if (r < 10) v = 0;
    else if (r < 20) v = 1023;
    else v = CfgDataW'($urandom_range(1, 40));
    write_reg(CFG_BAR_PITCH, v);

    r = $urandom_range(0, 99);
    if (r < 15) v = 0;
    else if (r < 30) v = 63;
    else v = CfgDataW'($urandom_range(1, 10));
    if ($urandom_range(0, 3) == 0) v = v | (CfgDataW'($urandom) << SpanW);
    write_reg(CFG_BAR_SPAN, v);

    write_reg(CFG_ERASE_COLOR, CfgDataW'($urandom));
    settings_seen++;
  endtask

  // Heights around the interesting points of the current screen height
  function automatic logic [HeightW-1:0] random_height();
    int unsigned r;
    int          sh;
    sh = int'(cfg_m.screen_height);
    r  = $urandom_range(0, 99);
    if (r < 10) return HeightW'($urandom);
    if (r < 18) return HeightW'(-int'($urandom_range(1, 32768)));
    if (r < 26) return HeightW'(sh + int'($urandom_range(1, 2000)));
    if (r < 40) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return HeightW'(1);
        2:       return HeightW'(sh);
        default: return HeightW'(sh - 1);
      endcase
    end
    return HeightW'($urandom_range(0, sh));
  endfunction

  initial begin
    #RunLimit;
    $display("tb: errors");
    $finish;
  end

  initial begin
    int unsigned p;
    int unsigned k;
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.bar_index  = '0;
    in_if.new_height = '0;
    out_if.ready     = 1'b0;
    tx_burst         = 1'b0;
    rx_burst         = 1'b0;
    heights_sent     = 0;
    rects_seen       = 0;
    settings_seen    = 1;
    mismatches       = 0;
    cfg_m            = '{SCREEN_HEIGHT_RST, FIRST_BAR_X_RST, BAR_PITCH_RST, BAR_SPAN_RST,
                         ERASE_COLOR_RST};
    foreach (bar_heights[i]) bar_heights[i] = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: grow, shrink, equal, negative, one-row and clamped heights
    queue_height(0, 100);
    queue_height(0, 40);
    queue_height(0, 40);
    queue_height(0, -5);
    queue_height(0, 1);
    queue_height(0, 0);
    queue_height(31, 16'sh7FFF);
    queue_height(31, 16'sh8000);
    for (k = 1; k < 8; k++) queue_height(IdxW'(4 * k), HeightW'(20 * k));
    queue_height(1, 480);
    queue_height(2, 481);
    drain();

    // Shrink screen below stored heights; push columns past the edge
    write_reg(CFG_SCREEN_HEIGHT, 16'hFC64);
    write_reg(CFG_FIRST_BAR_X, 1023);
    write_reg(CFG_BAR_PITCH, 1023);
    write_reg(CFG_BAR_SPAN, 63);
    write_reg(CFG_ERASE_COLOR, 16'hFFFF);
    settings_seen++;
    queue_height(1, 50);
    queue_height(31, 99);
    queue_height(2, 16'sh7FFF);
    drain();

    // Empty screen: everything clamps to zero
    write_reg(CFG_SCREEN_HEIGHT, 0);
    settings_seen++;
    queue_height(3, 10);
    queue_height(1, 5);
    drain();

    // Tallest screen, narrowest bars at column zero
    write_reg(CFG_SCREEN_HEIGHT, 1023);
    write_reg(CFG_FIRST_BAR_X, 0);
    write_reg(CFG_BAR_PITCH, 0);
    write_reg(CFG_BAR_SPAN, 0);
    write_reg(CFG_ERASE_COLOR, 16'h5A5A);
    settings_seen++;
    queue_height(3, 1023);
    queue_height(3, 0);
    queue_height(3, 1024);
    drain();

    // Random phases; one with a long receiver hold, one with no idling at all
    for (p = 0; p < RandPhases; p++) begin
      random_config();
      tx_burst = (p == 3) || (p == 6);
      rx_burst = (p == 6);
      for (k = 0; k < PhaseItems; k++)
        queue_height(IdxW'($urandom_range(0, BAR_COUNT_DEF - 1)), random_height());
      if (p == 3) begin
        @(posedge clk_i);
        hold_req_cnt <= hold_req_cnt + 1;
      end
      drain();
    end

    mismatches += pending_rects.size();
    $display("summary: %0d bar heights sent, %0d rectangles checked, %0d register settings,",
             heights_sent, rects_seen, settings_seen);
    $display("         random idling on both sides plus a %0d-cycle receiver hold-off",
             HoldCycles);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
